// ===== src/ffpra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_pkg: shared types for the first-fit page run allocator
// Transaction payloads, result codes and the control/status bundles that link
// the controller to the datapath.
// ----------------------------------------------------------------------------
package ffpra_pkg;

    localparam int LEN_W    = 7;
    localparam int FIRST_W  = 6;
    localparam int STATUS_W = 2;
    localparam int START_W  = 6;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_BAD_START = 2'd2
    } status_t;

    typedef struct packed {
        logic               action;
        logic [LEN_W-1:0]   run_length;
        logic [FIRST_W-1:0] first_page;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_page;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_wr;
        logic scan;
        logic mark_wr;
        logic free_wr;
        logic respond;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_skip;
        logic in_free;
        logic addr_last;
        logic hit;
        logic miss;
        logic cnt_last;
        logic out_open;
    } sts_t;

endpackage
`default_nettype wire

// ===== src/ffpra_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_chan_if: valid/ready channel
// One transaction moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ffpra_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/ffpra_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_ctrl: allocator controller
// Sequences the map clear after reset, the scan, the mark and free passes and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module ffpra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ffpra_pkg::sts_t sts,
    output ffpra_pkg::cmd_t cmd
);
    import ffpra_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MARK  = 6'b001000,
        S_FREE  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (sts.in_skip)
                    begin
                        state_next = S_RESP;
                    end
                    else if (sts.in_free)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (sts.hit)
                begin
                    state_next = S_MARK;
                end
                else if (sts.miss)
                begin
                    state_next = S_RESP;
                end
            end
            S_MARK:
            begin
                cmd.mark_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_FREE:
            begin
                cmd.free_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_open)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/ffpra_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_dp: allocator datapath
// Page map memory, address and run counters, request fields and the output
// register.
// ----------------------------------------------------------------------------
module ffpra_dp #(
    parameter int PAGES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffpra_pkg::cmd_t       cmd,
    output ffpra_pkg::sts_t       sts,
    input  ffpra_pkg::req_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ffpra_pkg::rsp_item_t  out_item
);
    import ffpra_pkg::*;

    localparam int PW = $clog2(PAGES);
    localparam int CW = $clog2(PAGES + 1);
    localparam int XW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [PW-1:0] LAST_ADDR = PW'(PAGES - 1);
    localparam logic [XW-1:0] PAGES_X   = XW'(PAGES);

    logic page_mem [PAGES];

    logic [PW-1:0] addr_reg, addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] run_reg, run_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          issue_done_reg, issue_done_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0]       len_reg;
    logic [PW-1:0]       rd_addr_reg;
    logic                rd_data_reg;
    status_t             status_reg;
    logic [PW-1:0]       start_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [START_W-1:0]  out_start_reg;

    // request decode
    logic [XW-1:0] first_x, len_x, room_x, free_cnt_x;
    logic          in_free, in_bad, in_zero, alloc_empty;

    assign first_x     = XW'(in_item.first_page);
    assign len_x       = XW'(in_item.run_length);
    assign in_free     = (in_item.action == ACT_FREE);
    assign in_bad      = (first_x >= PAGES_X);
    assign in_zero     = (len_x == '0);
    assign alloc_empty = in_zero || (len_x > PAGES_X);
    // free run clipped at the end of the map
    assign room_x      = PAGES_X - first_x;
    assign free_cnt_x  = (len_x < room_x) ? len_x : room_x;

    // scan evaluation on the registered read data
    logic [CW-1:0] run_step;
    logic [CW-1:0] start_c;
    logic          hit, miss, issue;

    assign run_step = rd_data_reg ? '0 : (run_reg + CW'(1));
    assign hit      = cmd.scan && rd_pend_reg && (run_step == len_reg);
    assign miss     = cmd.scan && rd_pend_reg && !hit && (rd_addr_reg == LAST_ADDR);
    assign start_c  = CW'(rd_addr_reg) + CW'(1) - len_reg;
    assign issue    = cmd.scan && !issue_done_reg;

    assign sts.in_skip   = in_free ? (in_bad || in_zero) : alloc_empty;
    assign sts.in_free   = in_free;
    assign sts.addr_last = (addr_reg == LAST_ADDR);
    assign sts.hit       = hit;
    assign sts.miss      = miss;
    assign sts.cnt_last  = (cnt_reg == CW'(1));
    assign sts.out_open  = !out_valid_reg || out_ready;

    always_comb
    begin
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        rd_pend_next    = 1'b0;
        issue_done_next = issue_done_reg;
        out_valid_next  = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.respond)
        begin
            out_valid_next = 1'b1;
        end

        if (cmd.load)
        begin
            addr_next       = in_free ? PW'(first_x) : '0;
            cnt_next        = CW'(free_cnt_x);
            run_next        = '0;
            issue_done_next = 1'b0;
        end
        if (cmd.clear_wr || cmd.mark_wr || cmd.free_wr)
        begin
            addr_next = addr_reg + PW'(1);
        end
        if (cmd.mark_wr || cmd.free_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.scan)
        begin
            if (rd_pend_reg)
            begin
                run_next = run_step;
            end
            if (hit)
            begin
                addr_next = start_c[PW-1:0];
                cnt_next  = len_reg;
            end
            else if (issue)
            begin
                rd_pend_next    = 1'b1;
                addr_next       = addr_reg + PW'(1);
                issue_done_next = (addr_reg == LAST_ADDR);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            cnt_reg        <= '0;
            run_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            cnt_reg        <= cnt_next;
            run_reg        <= run_next;
            rd_pend_reg    <= rd_pend_next;
            issue_done_reg <= issue_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // page map: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr || cmd.mark_wr || cmd.free_wr)
        begin
            page_mem[addr_reg] <= cmd.mark_wr;
        end
        if (issue)
        begin
            rd_data_reg <= page_mem[addr_reg];
            rd_addr_reg <= addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg   <= CW'(len_x);
            start_reg <= '0;
            if (in_free)
            begin
                status_reg <= in_bad ? ST_BAD_START : ST_OK;
            end
            else
            begin
                status_reg <= ST_NO_ROOM;
            end
        end
        else if (hit)
        begin
            status_reg <= ST_OK;
            start_reg  <= start_c[PW-1:0];
        end
        if (cmd.respond)
        begin
            out_status_reg <= status_reg;
            out_start_reg  <= START_W'(start_reg);
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_item.status     = out_status_reg;
    assign out_item.start_page = out_start_reg;

endmodule
`default_nettype wire

// ===== src/first_fit_page_run_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_top: first-fit page run allocator
// Keeps a used/free bit per page; allocates the lowest run of free pages and
// frees runs on request, one result per request.
//
//   channel   dir  payload                                  role
//   request   in   action, run_length, first_page           allocate/free request
//   result    out  status, start_page                       one per request
//
// after reset the page map is cleared one page a cycle, with request.ready low
// until the last page has been written
// allocate: accept, scan for a free run through the map read port, mark the
// run's pages, then the result; a scan that finds no run goes to the result
// free: accept, clear the clipped run, result; rejected or empty: accept, result
// a pending result sits in the output register while the next request runs;
// a request completes only once that register has been taken
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_top #(
    parameter int PAGES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    ffpra_chan_if.sink   request,
    ffpra_chan_if.source result
);
    import ffpra_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffpra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffpra_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (request.payload),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_item  (result.payload)
    );

endmodule
`default_nettype wire

// ===== dv/tb_first_fit_page_run_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_run_allocator_top: self-checking bench for the allocator
// Drives allocate and free requests through the request channel and keeps its
// own copy of the page map to predict status and start page of each result.
// A directed opening covers the edge lengths, clipping and a full map; random
// traffic then mixes allocations of recorded runs with matching frees and
// noise, under random gaps on both channels outside one quiet block.
// ----------------------------------------------------------------------------
module tb_first_fit_page_run_allocator_top;
    import ffpra_pkg::*;

    localparam int PAGES      = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 200;
    localparam int RAND_ITEMS = 500;

    typedef struct {
        req_item_t req;
        bit        drain;
        bit        quiet;
    } stim_entry_t;

    typedef struct {
        logic [LEN_W-1:0]   len;
        logic [FIRST_W-1:0] first;
    } page_run_t;

    logic clk;
    logic rst_n;

    ffpra_chan_if #(.payload_t(req_item_t)) req_if ();
    ffpra_chan_if #(.payload_t(rsp_item_t)) rsp_if ();

    first_fit_page_run_allocator_top #(
        .PAGES(PAGES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_if),
        .result (rsp_if)
    );

    stim_entry_t      pending_reqs[$];
    rsp_item_t        pending_results[$];
    page_run_t        owned_runs[$];
    logic [PAGES-1:0] page_map;
    logic [PAGES-1:0] next_map;
    logic [PAGES-1:0] plan_map;
    logic [PAGES-1:0] plan_next;
    stim_entry_t      cur_entry;
    rsp_item_t        want;
    bit               req_fire;
    bit               rsp_fire;
    bit               cur_quiet;
    bit               gen_quiet;
    int               gap_left;
    int               stall_left;
    int               idle_cycles;
    int               errors;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // page map update and result for one request
    function automatic rsp_item_t apply_request(input req_item_t req,
                                                input logic [PAGES-1:0] map_in,
                                                output logic [PAGES-1:0] map_out);
        rsp_item_t rsp;
        int        len;
        int        first;
        int        run;
        int        hit;
        rsp.status     = ST_OK;
        rsp.start_page = '0;
        map_out        = map_in;
        len            = int'(req.run_length);
        first          = int'(req.first_page);
        if (req.action == ACT_ALLOC)
        begin
            hit = -1;
            run = 0;
            if (len != 0 && len <= PAGES)
            begin
                for (int i = 0; i < PAGES; i++)
                begin
                    if (hit < 0)
                    begin
                        run = map_in[i] ? 0 : run + 1;
                        if (run == len)
                            hit = i + 1 - len;
                    end
                end
            end
            if (hit < 0)
                rsp.status = ST_NO_ROOM;
            else
            begin
                for (int i = 0; i < PAGES; i++)
                    if (i >= hit && i < hit + len)
                        map_out[i] = 1'b1;
                rsp.start_page = hit[START_W-1:0];
            end
        end
        else if (first >= PAGES)
            rsp.status = ST_BAD_START;
        else
        begin
            // run past the last page is clipped by the loop bound
            for (int i = 0; i < PAGES; i++)
                if (i >= first && i < first + len)
                    map_out[i] = 1'b0;
        end
        return rsp;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 100);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 100);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    // plans a request against the planning map so matching frees can follow
    task automatic queue_request(input logic act, input int len, input int first,
                                 input bit drain);
        stim_entry_t ent;
        page_run_t   pr;
        rsp_item_t   rsp;
        ent.req.action     = act;
        ent.req.run_length = len[LEN_W-1:0];
        ent.req.first_page = first[FIRST_W-1:0];
        ent.drain          = drain;
        ent.quiet          = gen_quiet;
        rsp = apply_request(ent.req, plan_map, plan_next);
        plan_map = plan_next;
        if (act == ACT_ALLOC && rsp.status == ST_OK)
        begin
            pr.len   = ent.req.run_length;
            pr.first = rsp.start_page;
            owned_runs.push_back(pr);
        end
        pending_reqs.push_back(ent);
    endtask

    task automatic plan_random_item();
        int        r;
        int        len;
        int        idx;
        page_run_t pr;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                len = $urandom_range(1, 8);
            else if (r < 97)
                len = $urandom_range(9, PAGES);
            else if (r < 98)
                len = 0;
            else
                len = $urandom_range(PAGES + 1, 127);
            queue_request(ACT_ALLOC, len, $urandom_range(0, 63), 1'b0);
        end
        else if (r < 80 && owned_runs.size() != 0)
        begin
            idx = $urandom_range(0, owned_runs.size() - 1);
            pr  = owned_runs[idx];
            owned_runs.delete(idx);
            queue_request(ACT_FREE, int'(pr.len), int'(pr.first), 1'b0);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(0, 8);
            else
                len = $urandom_range(9, 127);
            queue_request(ACT_FREE, len, $urandom_range(0, 63), 1'b0);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            gap_left     <= 0;
        end
        else if (!req_if.valid || req_fire)
        begin
            if (gap_left > 0)
            begin
                req_if.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && pending_results.size() != 0))
            begin
                cur_entry      = pending_reqs.pop_front();
                req_if.payload <= cur_entry.req;
                req_if.valid   <= 1'b1;
                cur_quiet      <= cur_entry.quiet;
                gap_left       <= pick_gap(cur_entry.quiet);
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!cur_quiet && $urandom_range(0, 15) == 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= pick_stall();
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        req_fire = rst_n && req_if.valid && req_if.ready;
        rsp_fire = rst_n && rsp_if.valid && rsp_if.ready;
        if (req_fire)
        begin
            pending_results.push_back(apply_request(req_if.payload, page_map, next_map));
            page_map = next_map;
        end
        if (rsp_fire)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d start %0d",
                                          rsp_if.payload.status, rsp_if.payload.start_page));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.payload.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_if.payload.status, want.status));
                if (rsp_if.payload.start_page !== want.start_page)
                    report_mismatch($sformatf("start_page got %0d want %0d",
                                              rsp_if.payload.start_page, want.start_page));
            end
        end
        if (req_fire || rsp_fire || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        page_map       = '0;
        plan_map       = '0;
        errors         = 0;
        idle_cycles    = 0;
        cur_quiet      = 1'b0;
        gen_quiet      = 1'b0;
        req_fire       = 1'b0;
        rsp_fire       = 1'b0;

        // directed: edge lengths, full map, clipping, frees of free pages
        queue_request(ACT_ALLOC, 0, 63, 1'b0);
        queue_request(ACT_ALLOC, PAGES + 1, 0, 1'b0);
        queue_request(ACT_ALLOC, 127, 42, 1'b0);
        queue_request(ACT_ALLOC, PAGES, 21, 1'b0);
        queue_request(ACT_ALLOC, 1, 0, 1'b1);
        queue_request(ACT_FREE, 1, 63, 1'b0);
        queue_request(ACT_ALLOC, 1, 0, 1'b0);
        queue_request(ACT_FREE, 127, 0, 1'b0);
        queue_request(ACT_FREE, 0, 63, 1'b0);
        queue_request(ACT_FREE, 5, 10, 1'b0);
        queue_request(ACT_ALLOC, 1, 63, 1'b0);
        queue_request(ACT_ALLOC, 3, 0, 1'b0);
        queue_request(ACT_ALLOC, 60, 0, 1'b0);
        queue_request(ACT_FREE, 2, 2, 1'b0);
        queue_request(ACT_ALLOC, 3, 0, 1'b0);
        queue_request(ACT_ALLOC, 2, 0, 1'b0);
        queue_request(ACT_FREE, 127, 40, 1'b0);
        queue_request(ACT_ALLOC, 24, 0, 1'b0);
        queue_request(ACT_FREE, 64, 0, 1'b0);
        owned_runs.delete();

        // random blocks, each opening after the block ahead has drained
        for (int b = 0; b < 5; b++)
        begin
            gen_quiet = (b == 2);
            queue_request(ACT_ALLOC, $urandom_range(1, 8), $urandom_range(0, 63), 1'b1);
            for (int n = 1; n < RAND_ITEMS / 5; n++)
                plan_random_item();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_if.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/ffpra_pkg.sv
src/ffpra_chan_if.sv
src/ffpra_ctrl.sv
src/ffpra_dp.sv
src/first_fit_page_run_allocator_top.sv
dv/tb_first_fit_page_run_allocator_top.sv
